[hw/rtl/pbo_pkg.sv]
package pbo_pkg;

	// Field widths of the channels and registers.
	localparam int OP_W     = 2;
	localparam int OFFSET_W = 25;
	localparam int SAMPLE_W = 18;
	localparam int INC_W    = 24;
	localparam int SHAPE_W  = 2;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	// Residual arithmetic: 15 quotient bits, a 16-bit Q15 ratio and a wide accumulator.
	localparam int QUO_W = 15;
	localparam int RAT_W = 16;
	localparam int PRD_W = 2 * RAT_W;
	localparam int ACC_W = 20;
	localparam int IDX_W = 2;
	localparam int CNT_W = 4;

	localparam logic [IDX_W-1:0] LAST_IDX  = 2'd3;
	localparam logic [CNT_W-1:0] LAST_STEP = 4'd14;

	// Operation codes of an input transaction.
	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_OFFSET = 2'd1;
	localparam logic [OP_W-1:0] OP_ZERO   = 2'd2;

	// Wave shapes; the unused code plays as triangle.
	localparam logic [SHAPE_W-1:0] SHAPE_SAW    = 2'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_TRI    = 2'd2;

	// Register index taken from the word address bit.
	localparam logic REG_INC   = 1'b0;
	localparam logic REG_SHAPE = 1'b1;

	// Q15 levels used by the naive waveforms, and the full-scale divider ratio.
	localparam logic signed [ACC_W-1:0] Q15_ONE  = 20'sd32768;
	localparam logic signed [ACC_W-1:0] Q15_TWO  = 20'sd65536;
	localparam logic signed [ACC_W-1:0] Q15_FOUR = 20'sd131072;
	localparam logic [RAT_W-1:0]        RAT_FULL = 16'h8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NAIVE,
		ST_TERM,
		ST_DIV,
		ST_SQUARE,
		ST_ACCUM,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             take;
		logic             naive;
		logic             load;
		logic             step;
		logic             square;
		logic             accum;
		logic             emit;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic term_en;
	} sts_t;

endpackage

[hw/rtl/pbo_in_if.sv]
interface pbo_in_if import pbo_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            op;
	logic signed [OFFSET_W-1:0] phase_offset;

	modport source (output valid, output op, output phase_offset, input ready);
	modport sink (input valid, input op, input phase_offset, output ready);
endinterface

[hw/rtl/pbo_out_if.sv]
interface pbo_out_if import pbo_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[hw/rtl/polyblep_oscillator.sv]
// Band-limited phase-accumulator oscillator with polyBLEP step correction.
// Input channel (item): op 0 asks for one sample and advances the phase by
// the increment, op 1 adds phase_offset (Q1.24) to the phase modulo one, op 2
// clears the phase, op 3 does nothing. Only op 0 yields a transaction on the
// result channel, carrying sample as signed Q3.15.
// Registers on the APB port: phase_increment at 0x0 (Q0.24; zero or half a
// cycle and above means a still phase), wave_shape at 0x4 (0 saw, 1 square,
// 2 triangle). Write them only while the block is idle.
// Offset and reset transactions complete on acceptance. A tick runs from
// acceptance to a valid result via the naive waveform and the active correction
// terms (0 to 2): each one runs a 15-step shift-subtract divider by the
// increment, then a squaring multiply and an accumulate. The block handles one
// tick at a time; it is ready again once the sample is in the output register.
// If the receiver stalls, the result holds in the output register; the next
// item is still taken, and its sample waits until that register is free.
// Reset clears the phase, both registers and the output valid flag.
module polyblep_oscillator import pbo_pkg::*; #(
	parameter int PHASE_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	pbo_in_if.sink            item,
	pbo_out_if.source         result
);

	logic [INC_W-1:0]   phase_increment;
	logic [SHAPE_W-1:0] wave_shape;
	cmd_t               cmd;
	sts_t               sts;

	pbo_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.phase_increment (phase_increment),
		.wave_shape      (wave_shape)
	);

	pbo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pbo_dp #(
		.PHASE_BITS (PHASE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (item.op),
		.phase_offset    (item.phase_offset),
		.phase_increment (phase_increment),
		.wave_shape      (wave_shape),
		.cmd             (cmd),
		.sts             (sts),
		.sample          (result.sample)
	);

endmodule

[hw/rtl/pbo_cfg.sv]
module pbo_cfg import pbo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output logic [INC_W-1:0]   phase_increment,
	output logic [SHAPE_W-1:0] wave_shape
);

	logic [INC_W-1:0]   inc_q;
	logic [SHAPE_W-1:0] shape_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= '0;
			shape_q <= SHAPE_SAW;
		end else if (wr_en) begin
			if (paddr[2] == REG_SHAPE) begin
				shape_q <= pwdata[SHAPE_W-1:0];
			end else begin
				inc_q <= pwdata[INC_W-1:0];
			end
		end
	end

	// Read back.
	always_comb begin
		if (paddr[2] == REG_SHAPE) begin
			prdata = {{(DATA_W-SHAPE_W){1'b0}}, shape_q};
		end else begin
			prdata = {{(DATA_W-INC_W){1'b0}}, inc_q};
		end
	end

	assign phase_increment = inc_q;
	assign wave_shape      = shape_q;

endmodule

[hw/rtl/pbo_ctrl.sv]
module pbo_ctrl import pbo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.is_tick) state_d = ST_NAIVE;
			end
			ST_NAIVE: state_d = ST_TERM;
			ST_TERM: begin
				if (sts.term_en) state_d = ST_DIV;
				else if (idx_q == LAST_IDX) state_d = ST_DONE;
			end
			ST_DIV: begin
				if (cnt_q == LAST_STEP) state_d = ST_SQUARE;
			end
			ST_SQUARE: state_d = ST_ACCUM;
			ST_ACCUM: begin
				if (idx_q == LAST_IDX) state_d = ST_DONE;
				else state_d = ST_TERM;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands for the datapath.
	always_comb begin
		cmd      = '0;
		cmd.idx  = idx_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_NAIVE:  cmd.naive  = 1'b1;
			ST_TERM:   cmd.load   = sts.term_en;
			ST_DIV:    cmd.step   = 1'b1;
			ST_SQUARE: cmd.square = 1'b1;
			ST_ACCUM:  cmd.accum  = 1'b1;
			ST_DONE:   cmd.emit   = out_free;
			default:   cmd.take   = 1'b0;
		endcase
	end

	// State, term index, divider step count and the result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NAIVE) begin
				idx_q <= '0;
			end else if (idx_q != LAST_IDX && ((state_q == ST_TERM && !sts.term_en) ||
					state_q == ST_ACCUM)) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_TERM) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/pbo_dp.sv]
module pbo_dp import pbo_pkg::*; #(
	parameter int PHASE_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [OP_W-1:0]            op,
	input  logic signed [OFFSET_W-1:0] phase_offset,
	input  logic [INC_W-1:0]           phase_increment,
	input  logic [SHAPE_W-1:0]         wave_shape,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	output logic signed [SAMPLE_W-1:0] sample
);

	localparam int P = PHASE_BITS;
	localparam logic [P-1:0] HALF    = {1'b1, {(P-1){1'b0}}};
	localparam logic [P-1:0] QUARTER = {2'b01, {(P-2){1'b0}}};
	localparam logic [P-1:0] THREE_Q = {2'b11, {(P-2){1'b0}}};
	localparam logic [P:0]   HALF_W  = {2'b01, {(P-1){1'b0}}};

	logic [P-1:0]               phase_q;
	logic [P-1:0]               p_q;
	logic [P-1:0]               inc_q;
	logic [P-1:0]               rem_q;
	logic [QUO_W-1:0]           quo_q;
	logic                       full_q;
	logic                       neg_q;
	logic                       dbl_q;
	logic [PRD_W-1:0]           prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [P+INC_W-1:0]    inc_w;
	logic [P+OFFSET_W-1:0] off_w;
	logic [P-1:0]          inc_scaled;
	logic [P-1:0]          inc_eff;
	logic [P-1:0]          off_scaled;

	// Increment and offset rescaled from Q.24 to the phase width.
	assign inc_w      = {phase_increment, {P{1'b0}}};
	assign off_w      = {phase_offset, {P{1'b0}}};
	assign inc_scaled = inc_w[P+INC_W-1:INC_W];
	assign off_scaled = off_w[P+INC_W-1:INC_W];
	assign inc_eff    = inc_scaled[P-1] ? '0 : inc_scaled;

	assign sts.is_tick = (op == OP_TICK);

	// Phase accumulator and the working copy of phase and increment for a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.take) begin
			case (op)
				OP_TICK:   phase_q <= phase_q + inc_eff;
				OP_OFFSET: phase_q <= phase_q + off_scaled;
				OP_ZERO:   phase_q <= '0;
				default:   phase_q <= phase_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			p_q   <= phase_q;
			inc_q <= inc_eff;
		end
	end

	// Naive waveform in Q15.
	logic [P+15:0]           p_x2;
	logic [P+16:0]           p_x4;
	logic signed [ACC_W-1:0] two_p;
	logic signed [ACC_W-1:0] four_p;
	logic signed [ACC_W-1:0] naive_v;

	assign p_x2   = {p_q, 16'b0};
	assign p_x4   = {p_q, 17'b0};
	assign two_p  = $signed({4'b0, p_x2[P+15:P]});
	assign four_p = $signed({3'b0, p_x4[P+16:P]});

	always_comb begin
		case (wave_shape)
			SHAPE_SAW:    naive_v = two_p - Q15_ONE;
			SHAPE_SQUARE: naive_v = p_q[P-1] ? -Q15_ONE : Q15_ONE;
			default: begin
				case (p_q[P-1:P-2])
					2'b00:   naive_v = four_p;
					2'b11:   naive_v = four_p - Q15_FOUR;
					default: naive_v = Q15_TWO - four_p;
				endcase
			end
		endcase
	end

	// Candidate correction terms near each step or corner of the waveform.
	logic [P:0]   pi;
	logic [P-1:0] n_lead, n_wrap, p_hi, n_post, n_pre, d1, d3;
	logic         term_en, term_neg, term_dbl;
	logic [P-1:0] term_n;

	assign pi     = {1'b0, p_q} + {1'b0, inc_q};
	assign n_lead = inc_q - p_q;
	assign n_wrap = pi[P-1:0];
	assign p_hi   = {1'b0, p_q[P-2:0]};
	assign n_post = inc_q - p_hi;
	assign n_pre  = pi[P-1:0] - HALF;
	assign d1     = (p_q >= QUARTER) ? p_q - QUARTER : QUARTER - p_q;
	assign d3     = (p_q >= THREE_Q) ? p_q - THREE_Q : THREE_Q - p_q;

	always_comb begin
		term_en  = 1'b0;
		term_neg = 1'b0;
		term_dbl = 1'b0;
		term_n   = n_lead;
		case (wave_shape)
			SHAPE_SAW: begin
				case (cmd.idx)
					2'd0: term_en = p_q < inc_q;
					2'd1: begin
						term_en  = pi[P];
						term_n   = n_wrap;
						term_neg = 1'b1;
					end
					default: term_en = 1'b0;
				endcase
			end
			SHAPE_SQUARE: begin
				case (cmd.idx)
					2'd0: begin
						term_en  = p_q < inc_q;
						term_neg = 1'b1;
					end
					2'd1: begin
						term_en = pi[P];
						term_n  = n_wrap;
					end
					2'd2: begin
						term_en = p_q[P-1] && (p_hi < inc_q);
						term_n  = n_post;
					end
					default: begin
						term_en  = !p_q[P-1] && (pi >= HALF_W);
						term_n   = n_pre;
						term_neg = 1'b1;
					end
				endcase
			end
			default: begin
				term_dbl = 1'b1;
				case (cmd.idx)
					2'd0: begin
						term_en  = d1 < inc_q;
						term_n   = d1;
						term_neg = 1'b1;
					end
					2'd1: begin
						term_en = d3 < inc_q;
						term_n  = d3;
					end
					default: term_en = 1'b0;
				endcase
			end
		endcase
	end

	assign sts.term_en = term_en;

	// Restoring divider: one quotient bit of n * 2^15 / inc per step.
	logic [P:0] rem_x2;
	logic       fits;

	assign rem_x2 = {rem_q, 1'b0};
	assign fits   = rem_x2 >= {1'b0, inc_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= term_n;
			quo_q  <= '0;
			full_q <= (term_n == inc_q);
			neg_q  <= term_neg;
			dbl_q  <= term_dbl;
		end else if (cmd.step) begin
			if (fits) begin
				rem_q <= rem_x2[P-1:0] - inc_q;
			end else begin
				rem_q <= rem_x2[P-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	// Square the ratio, then scale and accumulate the residual.
	logic [RAT_W-1:0]        ratio;
	logic [RAT_W:0]          resid;
	logic [RAT_W+1:0]        mag;
	logic signed [ACC_W-1:0] mag_ext;

	assign ratio   = full_q ? RAT_FULL : {1'b0, quo_q};
	assign resid   = prod_q[PRD_W-1:QUO_W];
	assign mag     = dbl_q ? {resid, 1'b0} : {1'b0, resid};
	assign mag_ext = $signed({{(ACC_W-RAT_W-2){1'b0}}, mag});

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			prod_q <= ratio * ratio;
		end
		if (cmd.naive) begin
			acc_q <= naive_v;
		end else if (cmd.accum) begin
			acc_q <= neg_q ? acc_q - mag_ext : acc_q + mag_ext;
		end
		if (cmd.emit) begin
			sample_q <= acc_q[SAMPLE_W-1:0];
		end
	end

	assign sample = sample_q;

endmodule
